### rtl/core/bmsi_pkg.sv
// Shared types, codes and constants for the banked mapper with scanline IRQ.
// No dependencies; every other file of the block but bmsi_ram uses this package.
package bmsi_pkg;

  // Work RAM size in bytes (power of two, 2048 to 8192)
  localparam int RAM_BYTES = 8192;
  localparam int RAM_AW    = $clog2(RAM_BYTES);

  localparam int CMD_W  = 3;
  localparam int ADDR_W = 16;
  localparam int DATA_W = 8;
  localparam int OFS_W  = 19;
  localparam int KIND_W = 2;
  localparam int BANKS_W = 6;
  localparam logic [BANKS_W-1:0] BANKS_RESET = 6'd2;

  // item commands
  localparam logic [CMD_W-1:0] CMD_CPU_RD  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_CPU_WR  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_PPU_RD  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_TICK    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_IRQ_ACK = 3'd4;

  // result target kinds
  localparam logic [KIND_W-1:0] KIND_PRG  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CHR  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RAM  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;

  // register window, from addr[14:13]
  localparam logic [1:0] WIN_BANK   = 2'd0;
  localparam logic [1:0] WIN_MIRROR = 2'd1;
  localparam logic [1:0] WIN_RELOAD = 2'd2;
  localparam logic [1:0] WIN_IRQ    = 2'd3;

  typedef struct packed {
    logic              handled;
    logic [KIND_W-1:0] target_kind;
    logic [OFS_W-1:0]  rom_offset;
    logic              irq_line;
    logic              mirror_mode;
  } result_t;

  typedef struct packed {
    logic              rd;
    logic              wr;
    logic [RAM_AW-1:0] addr;
    logic [DATA_W-1:0] wdata;
  } ram_req_t;

endpackage

### rtl/core/bmsi_item_if.sv
// Input item channel: valid/ready handshake carrying one bus item.
// Depends on bmsi_pkg for field widths.
interface bmsi_item_if;
  logic                         valid;
  logic                         ready;
  logic [bmsi_pkg::CMD_W-1:0]   cmd;
  logic [bmsi_pkg::ADDR_W-1:0]  addr;
  logic [bmsi_pkg::DATA_W-1:0]  data;

  modport source (output valid, cmd, addr, data, input ready);
  modport sink   (input valid, cmd, addr, data, output ready);
endinterface

### rtl/core/bmsi_res_if.sv
// Result channel: valid/ready handshake carrying one result item.
// Depends on bmsi_pkg for field widths.
interface bmsi_res_if;
  logic                         valid;
  logic                         ready;
  logic                         handled;
  logic [bmsi_pkg::KIND_W-1:0]  target_kind;
  logic [bmsi_pkg::OFS_W-1:0]   rom_offset;
  logic [bmsi_pkg::DATA_W-1:0]  read_data;
  logic                         irq_line;
  logic                         mirror_mode;

  modport source (output valid, handled, target_kind, rom_offset, read_data, irq_line,
                  mirror_mode, input ready);
  modport sink   (input valid, handled, target_kind, rom_offset, read_data, irq_line,
                  mirror_mode, output ready);
endinterface

### rtl/core/bmsi_cfg_if.sv
// Configuration write channel: valid/ready with the bank count as write data.
// Depends on bmsi_pkg for the data width.
interface bmsi_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [bmsi_pkg::BANKS_W-1:0]  data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

### rtl/core/banked_mapper_scanline_irq.sv
// Top level of the banked cartridge mapper with scanline interrupt.
// Depends on bmsi_pkg, the three channel interfaces, bmsi_regs and bmsi_ram.
//
//  channel | dir | payload                                         | handshake
//  --------+-----+-------------------------------------------------+----------
//  req     | in  | cmd, addr, data                                 | valid/ready
//  rsp     | out | handled, target_kind, rom_offset, read_data,    | valid/ready
//          |     | irq_line, mirror_mode                           |
//  cfg     | in  | data (prg_banks_16k)                            | valid/ready
//
// One item per cycle while rsp.ready is high and no clearing pass runs. An
// item waits in s1 on the registered work RAM read, then in output register s2.
// After reset a clearing pass zeroes the work RAM one byte a cycle; req.ready
// stays low until all RAM_BYTES (8192) bytes are cleared. cfg.ready is always high.
// rsp stalls back up through a two-deep pipe; req.ready depends on rsp.ready.
module banked_mapper_scanline_irq (
  input  logic        clk,
  input  logic        rst,
  bmsi_item_if.sink   req,
  bmsi_res_if.source  rsp,
  bmsi_cfg_if.sink    cfg
);
  import bmsi_pkg::*;

  // configuration register
  logic [BANKS_W-1:0] prg_banks;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      prg_banks <= BANKS_RESET;
    end else if (cfg.valid) begin
      prg_banks <= cfg.data;
    end
  end

  // work RAM clearing pass after reset
  logic              clearing;
  logic [RAM_AW-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == RAM_AW'(RAM_BYTES - 1)) clearing <= 1'b0;
    end
  end

  // pipe control: s1 waits on the RAM read, s2 is the output register
  logic          s1_valid, s2_valid, s1_rd, s1_adv, accept;
  result_t       s1_res, s2_res, cur_res;
  ram_req_t      ram_req;
  logic [DATA_W-1:0] ram_rdata, s2_rdata;

  assign s1_adv    = !s2_valid || rsp.ready;
  assign req.ready = !clearing && (!s1_valid || s1_adv);
  assign accept    = req.valid && req.ready;

  bmsi_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .cmd       (req.cmd),
    .addr      (req.addr),
    .data      (req.data),
    .prg_banks (prg_banks),
    .res       (cur_res),
    .ram_req   (ram_req)
  );

  // a write lands at its own acceptance edge, so a read one item later sees it
  bmsi_ram #(
    .WIDTH (DATA_W),
    .DEPTH (RAM_BYTES)
  ) u_work_ram (
    .clk   (clk),
    .we    (clearing || (accept && ram_req.wr)),
    .waddr (clearing ? clr_addr : ram_req.addr),
    .wdata (clearing ? '0 : ram_req.wdata),
    .re    (accept && ram_req.rd),
    .raddr (ram_req.addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) s2_valid <= s1_valid;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_res <= cur_res;
      s1_rd  <= ram_req.rd;
    end
    if (s1_adv) begin
      s2_res   <= s1_res;
      s2_rdata <= s1_rd ? ram_rdata : '0;
    end
  end

  assign rsp.valid       = s2_valid;
  assign rsp.handled     = s2_res.handled;
  assign rsp.target_kind = s2_res.target_kind;
  assign rsp.rom_offset  = s2_res.rom_offset;
  assign rsp.read_data   = s2_rdata;
  assign rsp.irq_line    = s2_res.irq_line;
  assign rsp.mirror_mode = s2_res.mirror_mode;

  // no item enters while the RAM is being cleared
  a_no_accept_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !req.ready)
    else $error("item accepted during RAM clear");

  // reset always starts a clearing pass
  a_reset_clears: assert property (@(posedge clk)
    rst |=> clearing && clr_addr == '0)
    else $error("reset did not start RAM clear");

  // an accepted item occupies s1 in the next cycle
  a_accept_fills_s1: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid)
    else $error("accepted item lost before s1");

  // a stalled s1 keeps its item and its RAM read data
  a_s1_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |=> s1_valid && $stable(s1_res) && $stable(ram_rdata))
    else $error("stalled s1 item changed");

  // s1 never overwritten while it cannot move on
  a_s1_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |-> !accept)
    else $error("s1 overwritten while stalled");

endmodule

### rtl/core/bmsi_ram.sv
// Generic single-clock RAM, one write port and one registered read port.
// No dependencies.
module bmsi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/bmsi_regs.sv
// Mapper register file, bank mapping and scanline counter.
// Depends on bmsi_pkg; state updates on each accepted item.
module bmsi_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic [bmsi_pkg::CMD_W-1:0]    cmd,
  input  logic [bmsi_pkg::ADDR_W-1:0]   addr,
  input  logic [bmsi_pkg::DATA_W-1:0]   data,
  input  logic [bmsi_pkg::BANKS_W-1:0]  prg_banks,
  output bmsi_pkg::result_t             res,
  output bmsi_pkg::ram_req_t            ram_req
);
  import bmsi_pkg::*;

  logic [7:0] bank_regs [8];
  logic [2:0] select_index;
  logic       prg_swap_mode;
  logic       chr_invert_mode;
  logic       mirror_bit;
  logic [7:0] line_reload;
  logic [7:0] line_counter;
  logic       irq_enabled;
  logic       irq_pending;

  logic [7:0] line_counter_next;
  logic       irq_enabled_next;
  logic       irq_pending_next;
  logic       mirror_bit_next;

  logic       cpu_rd, cpu_wr, ppu_rd, is_prg, is_ram, reg_wr, odd;
  logic [5:0] last_bank, second_bank, prg_bank;
  logic [2:0] slot;
  logic [7:0] chr_bank, chr_reg;
  logic [7:0] tick_count;

  assign cpu_rd = (cmd == CMD_CPU_RD);
  assign cpu_wr = (cmd == CMD_CPU_WR);
  assign ppu_rd = (cmd == CMD_PPU_RD);
  assign is_prg = addr[15];
  assign is_ram = (addr[15:13] == 3'b011);
  assign reg_wr = cpu_wr && is_prg;
  assign odd    = addr[0];

  // program windows
  assign last_bank   = {prg_banks[4:0], 1'b0} - 6'd1;
  assign second_bank = {prg_banks[4:0], 1'b0} - 6'd2;

  always_comb begin
    unique case (addr[14:13])
      2'd0:    prg_bank = prg_swap_mode ? second_bank : bank_regs[6][5:0];
      2'd1:    prg_bank = bank_regs[7][5:0];
      2'd2:    prg_bank = prg_swap_mode ? bank_regs[6][5:0] : second_bank;
      default: prg_bank = last_bank;
    endcase
  end

  // character windows: two 2 KiB pairs and four 1 KiB slots, halves swapped by chr_invert_mode
  assign slot = addr[12:10] ^ {chr_invert_mode, 2'b00};
  assign chr_reg = slot[2] ? bank_regs[{1'b0, slot[1:0]} + 3'd2] : bank_regs[{2'b00, slot[1]}];
  assign chr_bank = slot[2] ? chr_reg : {chr_reg[7:1], slot[0]};

  assign tick_count = (line_counter == 8'd0) ? line_reload : line_counter - 8'd1;

  always_comb begin
    line_counter_next = line_counter;
    irq_enabled_next  = irq_enabled;
    irq_pending_next  = irq_pending;
    mirror_bit_next   = mirror_bit;
    if (reg_wr) begin
      unique case (addr[14:13])
        WIN_MIRROR: if (!odd) mirror_bit_next = data[0];
        WIN_RELOAD: if (odd) line_counter_next = 8'd0;
        WIN_IRQ: begin
          if (odd) begin
            irq_enabled_next = 1'b1;
          end else begin
            irq_enabled_next = 1'b0;
            irq_pending_next = 1'b0;
          end
        end
        default: ;
      endcase
    end else if (cmd == CMD_TICK) begin
      line_counter_next = tick_count;
      if (tick_count == 8'd0 && irq_enabled) irq_pending_next = 1'b1;
    end else if (cmd == CMD_IRQ_ACK) begin
      irq_pending_next = 1'b0;
    end
  end

  always_comb begin
    res.handled     = 1'b0;
    res.target_kind = KIND_NONE;
    res.rom_offset  = '0;
    res.irq_line    = irq_pending_next;
    res.mirror_mode = mirror_bit_next;
    if (cpu_rd && is_prg) begin
      res.handled     = 1'b1;
      res.target_kind = KIND_PRG;
      res.rom_offset  = {prg_bank, addr[12:0]};
    end else if ((cpu_rd || cpu_wr) && is_ram) begin
      res.handled     = 1'b1;
      res.target_kind = KIND_RAM;
    end else if (ppu_rd && addr[15:13] == 3'b000) begin
      res.handled     = 1'b1;
      res.target_kind = KIND_CHR;
      res.rom_offset  = {1'b0, chr_bank, addr[9:0]};
    end
  end

  assign ram_req.rd    = cpu_rd && is_ram;
  assign ram_req.wr    = cpu_wr && is_ram;
  assign ram_req.addr  = addr[RAM_AW-1:0];
  assign ram_req.wdata = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 8; i++) bank_regs[i] <= 8'd0;
      select_index    <= 3'd0;
      prg_swap_mode   <= 1'b0;
      chr_invert_mode <= 1'b0;
      mirror_bit      <= 1'b1;
      line_reload     <= 8'd0;
      line_counter    <= 8'd0;
      irq_enabled     <= 1'b0;
      irq_pending     <= 1'b0;
    end else if (accept) begin
      line_counter <= line_counter_next;
      irq_enabled  <= irq_enabled_next;
      irq_pending  <= irq_pending_next;
      mirror_bit   <= mirror_bit_next;
      if (reg_wr && addr[14:13] == WIN_BANK) begin
        if (odd) begin
          bank_regs[select_index] <= data;
        end else begin
          select_index    <= data[2:0];
          prg_swap_mode   <= data[6];
          chr_invert_mode <= data[7];
        end
      end
      if (reg_wr && addr[14:13] == WIN_RELOAD && !odd) line_reload <= data;
    end
  end

endmodule

### tb/sv/bmsi_mapper_checker.sv
`timescale 1ns / 100ps
// Result checker for the banked mapper: watches the request, result and config
// channels, predicts each result and compares it. Needs bmsi_pkg and the channel interfaces.
module bmsi_mapper_checker (
  input  logic clk,
  input  logic rst,
  bmsi_item_if req,
  bmsi_res_if  rsp,
  bmsi_cfg_if  cfg,
  output int   fail_count,
  output int   pending_results
);
  import bmsi_pkg::*;

  typedef struct packed {
    logic              handled;
    logic [KIND_W-1:0] target_kind;
    logic [OFS_W-1:0]  rom_offset;
    logic [DATA_W-1:0] read_data;
    logic              irq_line;
    logic              mirror_mode;
  } mapper_out_t;

  // mapper state as seen from the bus
  logic [DATA_W-1:0]  ram_copy [RAM_BYTES];
  logic [7:0]         bank_reg [8];
  logic [2:0]         sel_idx;
  logic               prg_swap;
  logic               chr_invert;
  logic               mirror_h;
  logic [7:0]         reload_val;
  logic [7:0]         line_cnt;
  logic               irq_en;
  logic               irq_pend;
  logic [BANKS_W-1:0] prg_banks;

  mapper_out_t expected_out_q [$];
  mapper_out_t oldest;

  function automatic logic [OFS_W-1:0] prg_rom_offset(input logic [ADDR_W-1:0] a);
    logic [5:0] last_bank;
    logic [5:0] second_bank;
    logic [5:0] bank;
    // 2n-1 and 2n-2 wrap modulo 64
    last_bank   = {prg_banks[4:0], 1'b0} - 6'd1;
    second_bank = {prg_banks[4:0], 1'b0} - 6'd2;
    case (a[14:13])
      2'd0:    bank = prg_swap ? second_bank : bank_reg[6][5:0];
      2'd1:    bank = bank_reg[7][5:0];
      2'd2:    bank = prg_swap ? bank_reg[6][5:0] : second_bank;
      default: bank = last_bank;
    endcase
    return {bank, a[12:0]};
  endfunction

  function automatic logic [OFS_W-1:0] chr_rom_offset(input logic [ADDR_W-1:0] a);
    logic [2:0] slot;
    logic [7:0] r;
    logic [7:0] bank;
    slot = a[12:10] ^ {chr_invert, 2'b00};
    if (!slot[2]) begin
      // 2 KiB pairs: even half R&~1, odd half R|1
      r = bank_reg[{2'b00, slot[1]}];
      bank = {r[7:1], slot[0]};
    end else begin
      bank = bank_reg[3'd2 + {1'b0, slot[1:0]}];
    end
    return {1'b0, bank, a[9:0]};
  endfunction

  function automatic void write_register(input logic [ADDR_W-1:0] a, input logic [DATA_W-1:0] d);
    case (a[14:13])
      WIN_BANK: begin
        if (!a[0]) begin
          sel_idx    = d[2:0];
          prg_swap   = d[6];
          chr_invert = d[7];
        end else begin
          bank_reg[sel_idx] = d;
        end
      end
      WIN_MIRROR: begin
        if (!a[0]) mirror_h = d[0];
      end
      WIN_RELOAD: begin
        if (!a[0]) reload_val = d;
        else line_cnt = '0;
      end
      default: begin
        if (!a[0]) begin
          irq_en   = 1'b0;
          irq_pend = 1'b0;
        end else begin
          irq_en = 1'b1;
        end
      end
    endcase
  endfunction

  function automatic mapper_out_t map_bus_item(input logic [CMD_W-1:0] c,
                                               input logic [ADDR_W-1:0] a,
                                               input logic [DATA_W-1:0] d);
    mapper_out_t r;
    int          ram_idx;
    r = '{handled: 1'b0, target_kind: KIND_NONE, rom_offset: '0, read_data: '0,
          irq_line: 1'b0, mirror_mode: 1'b0};
    ram_idx = int'(a[12:0]) % RAM_BYTES;
    case (c)
      CMD_CPU_RD: begin
        if (a[15]) begin
          r.handled = 1'b1;
          r.target_kind = KIND_PRG;
          r.rom_offset = prg_rom_offset(a);
        end else if (a >= 16'h6000) begin
          r.handled = 1'b1;
          r.target_kind = KIND_RAM;
          r.read_data = ram_copy[ram_idx];
        end
      end
      CMD_CPU_WR: begin
        if (a[15]) begin
          write_register(a, d);
        end else if (a >= 16'h6000) begin
          ram_copy[ram_idx] = d;
          r.handled = 1'b1;
          r.target_kind = KIND_RAM;
        end
      end
      CMD_PPU_RD: begin
        if (a < 16'h2000) begin
          r.handled = 1'b1;
          r.target_kind = KIND_CHR;
          r.rom_offset = chr_rom_offset(a);
        end
      end
      CMD_TICK: begin
        if (line_cnt == 8'd0) line_cnt = reload_val;
        else line_cnt = line_cnt - 8'd1;
        if (line_cnt == 8'd0 && irq_en) irq_pend = 1'b1;
      end
      CMD_IRQ_ACK: irq_pend = 1'b0;
      default: ;
    endcase
    r.irq_line = irq_pend;
    r.mirror_mode = mirror_h;
    return r;
  endfunction

  function automatic void compare_field(input string name, input int unsigned want,
                                        input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      foreach (ram_copy[i]) ram_copy[i] = '0;
      foreach (bank_reg[i]) bank_reg[i] = '0;
      sel_idx    = '0;
      prg_swap   = 1'b0;
      chr_invert = 1'b0;
      mirror_h   = 1'b1;
      reload_val = '0;
      line_cnt   = '0;
      irq_en     = 1'b0;
      irq_pend   = 1'b0;
      prg_banks  = BANKS_RESET;
      expected_out_q.delete();
      fail_count = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (expected_out_q.size() == 0) begin
          $display("%0t: result item with none expected", $time);
          fail_count++;
        end else begin
          oldest = expected_out_q.pop_front();
          compare_field("handled", oldest.handled, rsp.handled);
          compare_field("target_kind", oldest.target_kind, rsp.target_kind);
          compare_field("rom_offset", oldest.rom_offset, rsp.rom_offset);
          compare_field("read_data", oldest.read_data, rsp.read_data);
          compare_field("irq_line", oldest.irq_line, rsp.irq_line);
          compare_field("mirror_mode", oldest.mirror_mode, rsp.mirror_mode);
        end
      end
      if (cfg.valid && cfg.ready) prg_banks = cfg.data;
      if (req.valid && req.ready)
        expected_out_q.push_back(map_bus_item(req.cmd, req.addr, req.data));
    end
    pending_results = expected_out_q.size();
  end

endmodule

### tb/sv/banked_mapper_scanline_irq_test.sv
`timescale 1ns / 100ps
// Top of the mapper testbench: clock, reset, bus item stimulus and verdict.
// Needs bmsi_pkg, the channel interfaces, the block and bmsi_mapper_checker.
module banked_mapper_scanline_irq_test;
  import bmsi_pkg::*;

  logic clk;
  logic rst;
  int   fail_count;
  int   pending_results;

  bmsi_item_if req_if ();
  bmsi_res_if  rsp_if ();
  bmsi_cfg_if  cfg_if ();

  banked_mapper_scanline_irq uut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if),
    .cfg (cfg_if)
  );

  bmsi_mapper_checker checker_i (
    .clk             (clk),
    .rst             (rst),
    .req             (req_if),
    .rsp             (rsp_if),
    .cfg             (cfg_if),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop; reckons with the RAM clear plus all items at worst pacing.
  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Result side back-pressure: each window draws a new period and stall length;
  // about a third of windows never stall at all.
  int stall_tick = 0;
  int stall_period = 2;
  int stall_len = 0;

  initial rsp_if.ready = 1'b1;

  always @(posedge clk) begin
    if (stall_tick % 128 == 0) begin
      stall_period = $urandom_range(2, 8);
      stall_len = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, stall_period - 1);
    end
    rsp_if.ready <= (stall_tick % stall_period) >= stall_len;
    stall_tick++;
  end

  // Sender pacing: items go out in bursts of 1..32, with an idle gap drawn at random between.
  int burst_left = 0;
  int items_sent = 0;

  task automatic issue_item(input logic [CMD_W-1:0] c, input logic [ADDR_W-1:0] a,
                            input logic [DATA_W-1:0] d);
    int gap;
    if (burst_left == 0) begin
      req_if.valid <= 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 32);
    end
    req_if.valid <= 1'b1;
    req_if.cmd   <= c;
    req_if.addr  <= a;
    req_if.data  <= d;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    burst_left--;
    items_sent++;
  endtask

  // Stop sending and wait for every outstanding result, then let the clock run on
  // so the block is truly idle before a config write.
  task automatic quiesce();
    req_if.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_bank_count(input logic [BANKS_W-1:0] banks);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= banks;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // Directed pass: field extremes, each command, and the named corner cases.
  task automatic directed_items();
    // unmapped CPU reads: bottom of the map and just below the RAM window
    issue_item(CMD_CPU_RD, 16'h0000, 8'h00);
    issue_item(CMD_CPU_RD, 16'h5FFF, 8'hFF);
    // work RAM, both ends of the window, write then read back
    issue_item(CMD_CPU_WR, 16'h6000, 8'hFF);
    issue_item(CMD_CPU_WR, 16'h7FFF, 8'hA5);
    issue_item(CMD_CPU_RD, 16'h6000, 8'h00);
    issue_item(CMD_CPU_RD, 16'h7FFF, 8'h00);
    // R6 = 0xFF (top bits masked off on PRG), R7 = 0x81
    issue_item(CMD_CPU_WR, 16'h8000, 8'h06);
    issue_item(CMD_CPU_WR, 16'h8001, 8'hFF);
    issue_item(CMD_CPU_WR, 16'h8000, 8'h07);
    issue_item(CMD_CPU_WR, 16'h8001, 8'h81);
    // all four PRG windows, normal mode
    issue_item(CMD_CPU_RD, 16'h8000, 8'h00);
    issue_item(CMD_CPU_RD, 16'hA000, 8'h00);
    issue_item(CMD_CPU_RD, 16'hC000, 8'h00);
    issue_item(CMD_CPU_RD, 16'hFFFF, 8'h00);
    // PRG swap and CHR invert on, R0 = 0xFF
    issue_item(CMD_CPU_WR, 16'h9FFE, 8'hC0);
    issue_item(CMD_CPU_WR, 16'h9FFF, 8'hFF);
    issue_item(CMD_CPU_RD, 16'h8000, 8'h00);
    issue_item(CMD_CPU_RD, 16'hC000, 8'h00);
    // CHR: both halves of a 2 KiB pair, top of pattern space, unmapped PPU
    issue_item(CMD_PPU_RD, 16'h1000, 8'h00);
    issue_item(CMD_PPU_RD, 16'h17FF, 8'h00);
    issue_item(CMD_PPU_RD, 16'h1FFF, 8'h00);
    issue_item(CMD_PPU_RD, 16'h2000, 8'h00);
    // mirroring to vertical; the odd RAM-protect address does nothing
    issue_item(CMD_CPU_WR, 16'hA000, 8'h00);
    issue_item(CMD_CPU_WR, 16'hBFFF, 8'hFF);
    // scanline IRQ: reload 1, clear counter, enable, two ticks, acknowledge, disable
    issue_item(CMD_CPU_WR, 16'hC000, 8'h01);
    issue_item(CMD_CPU_WR, 16'hC001, 8'h00);
    issue_item(CMD_CPU_WR, 16'hE001, 8'h00);
    issue_item(CMD_TICK, 16'h0000, 8'h00);
    issue_item(CMD_TICK, 16'hFFFF, 8'hFF);
    issue_item(CMD_IRQ_ACK, 16'h0000, 8'h00);
    issue_item(CMD_CPU_WR, 16'hE000, 8'h00);
    // unused commands change nothing
    issue_item(3'd5, 16'h6000, 8'h55);
    issue_item(3'd7, 16'h8001, 8'hAA);
  endtask

  // One random stretch: mostly well-formed register and access sequences,
  // with a share of raw noise over every command and address.
  task automatic random_sequence();
    int                pick;
    int                n;
    logic [ADDR_W-1:0] a;
    logic [DATA_W-1:0] d;
    pick = $urandom_range(0, 9);
    case (pick)
      0: issue_item(3'($urandom), 16'($urandom), 8'($urandom));
      1: begin
        // bank select then bank data
        issue_item(CMD_CPU_WR, {1'b1, WIN_BANK, 12'($urandom), 1'b0}, 8'($urandom));
        issue_item(CMD_CPU_WR, {1'b1, WIN_BANK, 12'($urandom), 1'b1}, 8'($urandom));
      end
      2: begin
        n = $urandom_range(1, 4);
        repeat (n) issue_item(CMD_CPU_RD, {1'b1, 15'($urandom)}, 8'($urandom));
      end
      3: begin
        n = $urandom_range(1, 4);
        repeat (n) issue_item(CMD_PPU_RD, {3'b000, 13'($urandom)}, 8'($urandom));
      end
      4: begin
        // RAM write, maybe another access, then read back the same byte
        a = {3'b011, 13'($urandom)};
        d = 8'($urandom);
        issue_item(CMD_CPU_WR, a, d);
        if ($urandom_range(0, 1)) issue_item(CMD_CPU_RD, {3'b011, 13'($urandom)}, 8'($urandom));
        issue_item(CMD_CPU_RD, a, 8'($urandom));
      end
      5: issue_item(CMD_CPU_RD, {3'b011, 13'($urandom)}, 8'($urandom));
      6: begin
        // full scanline IRQ setup, a run of ticks, then an acknowledge or a disable
        issue_item(CMD_CPU_WR, {1'b1, WIN_RELOAD, 12'($urandom), 1'b0},
                   8'($urandom_range(0, 6)));
        issue_item(CMD_CPU_WR, {1'b1, WIN_RELOAD, 12'($urandom), 1'b1}, 8'($urandom));
        issue_item(CMD_CPU_WR, {1'b1, WIN_IRQ, 12'($urandom), 1'b1}, 8'($urandom));
        n = $urandom_range(0, 12);
        repeat (n) issue_item(CMD_TICK, 16'($urandom), 8'($urandom));
        if ($urandom_range(0, 1)) issue_item(CMD_IRQ_ACK, 16'($urandom), 8'($urandom));
        else issue_item(CMD_CPU_WR, {1'b1, WIN_IRQ, 12'($urandom), 1'b0}, 8'($urandom));
      end
      7: begin
        n = $urandom_range(1, 6);
        repeat (n) issue_item(CMD_TICK, 16'($urandom), 8'($urandom));
        if ($urandom_range(0, 2) == 0) issue_item(CMD_IRQ_ACK, 16'($urandom), 8'($urandom));
      end
      8: issue_item(CMD_CPU_WR, {1'b1, WIN_MIRROR, 12'($urandom), 1'($urandom)},
                    8'($urandom));
      default: issue_item(CMD_CPU_WR, {1'b1, 15'($urandom)}, 8'($urandom));
    endcase
  endtask

  // Bank counts per phase: the legal extremes, the out-of-range wraps, then random.
  logic [BANKS_W-1:0] bank_plan [6];
  int                 phase_target;

  initial begin
    rst          <= 1'b1;
    req_if.valid <= 1'b0;
    req_if.cmd   <= '0;
    req_if.addr  <= '0;
    req_if.data  <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.data  <= '0;
    bank_plan[0] = 6'd1;
    bank_plan[1] = 6'd32;
    bank_plan[2] = 6'd0;
    bank_plan[3] = 6'd63;
    bank_plan[4] = 6'($urandom_range(1, 32));
    bank_plan[5] = 6'($urandom);
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // the block clears its RAM first; issue_item simply waits on ready
    write_bank_count(BANKS_RESET);
    directed_items();
    quiesce();

    foreach (bank_plan[p]) begin
      write_bank_count(bank_plan[p]);
      phase_target = items_sent + 130;
      while (items_sent < phase_target) random_sequence();
      quiesce();
    end

    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending_results == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
